@@ rtl/core/wqt_pkg.sv @@
// Shared types, constants and helpers for the windowed quality trimmer.
package wqt_pkg;

  // Default depth of the read store.
  localparam int DEF_MAX_READ_LEN = 1024;

  // Width of the position fields in a result.
  localparam int POS_W = 11;

  // Register port address width (four 32-bit registers).
  localparam int PADDR_W = 4;

  // Automatic window sizing (window length 0): reads longer than this use length / WIN_DIVISOR.
  localparam int AUTO_WIN_MIN_LEN = 20;
  localparam int WIN_DIVISOR      = 10;

  // Register indexes.
  localparam logic [1:0] REG_QUAL_FLOOR     = 2'd0;
  localparam logic [1:0] REG_LEN_FLOOR      = 2'd1;
  localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd2;
  localparam logic [1:0] REG_QUALITY_OFFSET = 2'd3;

  // Register reset values.
  localparam logic [6:0]  RST_QUAL_FLOOR     = 7'd20;
  localparam logic [10:0] RST_LEN_FLOOR      = 11'd0;
  localparam logic [10:0] RST_WINDOW_LENGTH  = 11'd0;
  localparam logic [6:0]  RST_QUALITY_OFFSET = 7'd33;

  typedef struct packed {
    logic [6:0]  qual_floor;
    logic [10:0] len_floor;
    logic [10:0] window_length;
    logic [6:0]  quality_offset;
  } wqt_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] keep_start;
    logic [POS_W-1:0] keep_end;
    logic             dropped;
    logic             trimmed;
    logic [31:0]      reads_seen;
    logic [31:0]      reads_trimmed;
    logic [31:0]      reads_dropped;
  } wqt_result_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SIZE,
    ST_DIV,
    ST_SKIP,
    ST_PRESUM,
    ST_SLIDE,
    ST_EXTEND,
    ST_DONE
  } wqt_state_t;

  // Signed score of one quality character.
  function automatic logic signed [9:0] char_score(logic [7:0] c, logic [6:0] off);
    return $signed({2'b00, c}) - $signed({3'b000, off});
  endfunction

endpackage

@@ rtl/core/wqt_regs.sv @@
// Configuration register file behind the APB-style port.
module wqt_regs import wqt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output wqt_cfg_t           cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel & penable & pwrite & pready;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.qual_floor     <= RST_QUAL_FLOOR;
      cfg.len_floor      <= RST_LEN_FLOOR;
      cfg.window_length  <= RST_WINDOW_LENGTH;
      cfg.quality_offset <= RST_QUALITY_OFFSET;
    end else if (wr) begin
      case (idx)
        REG_QUAL_FLOOR:     cfg.qual_floor     <= pwdata[6:0];
        REG_LEN_FLOOR:      cfg.len_floor      <= pwdata[10:0];
        REG_WINDOW_LENGTH:  cfg.window_length  <= pwdata[10:0];
        REG_QUALITY_OFFSET: cfg.quality_offset <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (idx)
      REG_QUAL_FLOOR:     prdata = {25'd0, cfg.qual_floor};
      REG_LEN_FLOOR:      prdata = {21'd0, cfg.len_floor};
      REG_WINDOW_LENGTH:  prdata = {21'd0, cfg.window_length};
      REG_QUALITY_OFFSET: prdata = {25'd0, cfg.quality_offset};
      default:            prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/wqt_div10.sv @@
// Divide of a read length by the window divisor (reciprocal multiply).
module wqt_div10 import wqt_pkg::*; #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  output logic [W-1:0] quo,
  output logic         done
);

  localparam int S = W + 4;
  localparam logic [S-1:0] RECIP = S'((64'd1 << S) / WIN_DIVISOR);

  logic [W+S-1:0] prod;
  logic [W-1:0]   num_r;
  logic           busy;
  logic [W-1:0]   est;
  logic [W+3:0]   est_x10;
  logic [W+3:0]   rem;
  logic           bump;

  // Estimate is the quotient or one below it
  assign est     = prod[W+S-1:S];
  assign est_x10 = {1'b0, est, 3'b000} + {3'b000, est, 1'b0};
  assign rem     = {4'b0000, num_r} - est_x10;
  assign bump    = rem >= (W+4)'(WIN_DIVISOR);

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  // Multiply, then correct the estimate
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      prod  <= {{S{1'b0}}, num} * {{W{1'b0}}, RECIP};
    end
    if (busy) begin
      quo <= bump ? est + 1'b1 : est;
    end
  end

endmodule

@@ rtl/core/wqt_trim.sv @@
// Read store and trimming sequencer: loads a read, then walks the store to trim it.
module wqt_trim import wqt_pkg::*; #(
  parameter int MAX_READ_LEN = DEF_MAX_READ_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  wqt_cfg_t    cfg,
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  qual_char,
  input  logic        last,
  output logic        res_valid,
  input  logic        res_ready,
  output wqt_result_t res
);

  localparam int LW = $clog2(MAX_READ_LEN + 1);
  localparam int AW = $clog2(MAX_READ_LEN);
  localparam int CW = (LW > 11) ? LW : 11;
  localparam int SW = LW + 9;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_READ_LEN);

  wqt_state_t state, state_next;

  // Read store
  logic [7:0] mem [MAX_READ_LEN];
  logic [7:0] mem_q;

  logic [LW-1:0] cnt, cnt_inc, len, win, start_p, cur, ptr, end_p, tail_p, span;
  logic signed [SW-1:0] sum, limit, score_x, sum_eff;
  logic [LW+6:0] lim_prod;
  logic          sub, rd_pend, drop_early;
  logic [31:0]   seen_cnt, trim_cnt, drop_cnt;

  logic          accept, wr_en, rd_en;
  logic [LW:0]   rd_sel, cur_plus_win;
  logic signed [9:0] score;
  logic          score_ok, scan_cont, scan_end, presum_done, slide_end;
  logic          win_fit, add_ok, sum_lt, out_free;
  logic [CW-1:0] len_c, minlen_c, wl_c;
  logic [LW-1:0] win_cfg;
  logic          auto_win, drop_now, div_start, div_done;
  logic [LW-1:0] div_quo;
  logic          dropped_f, trimmed_f;

  wqt_div10 #(.W(LW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (len),
    .quo   (div_quo),
    .done  (div_done)
  );

  // Store writes while loading, registered reads while trimming
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt[AW-1:0]] <= qual_char;
    end
    if (rd_en) begin
      mem_q <= mem[rd_sel[AW-1:0]];
    end
  end

  // Shared datapath terms
  assign accept   = char_valid & char_ready;
  assign cnt_inc  = (cnt < MAX_LEN) ? cnt + 1'b1 : cnt;
  assign score    = char_score(mem_q, cfg.quality_offset);
  assign score_x  = {{(SW-10){score[9]}}, score};
  assign score_ok = score >= $signed({3'b000, cfg.qual_floor});
  assign len_c    = CW'(len);
  assign minlen_c = CW'(cfg.len_floor);
  assign wl_c     = CW'(cfg.window_length);
  assign win_cfg  = (wl_c > len_c) ? len : wl_c[LW-1:0];
  assign auto_win = len_c > CW'(AUTO_WIN_MIN_LEN);
  assign drop_now = len_c < minlen_c;
  assign lim_prod = (LW+7)'(cfg.qual_floor) * (LW+7)'(win);
  assign out_free = !res_valid || res_ready;

  assign cur_plus_win = {1'b0, cur} + {1'b0, win};
  assign win_fit      = cur_plus_win <= {1'b0, len};
  assign add_ok       = cur_plus_win < {1'b0, len};
  assign sum_eff      = sum + (rd_pend ? score_x : '0);
  assign sum_lt       = sum_eff < limit;

  // Skip scan advances on failing bases, extend scan on passing ones
  assign scan_cont   = rd_pend && ((state == ST_SKIP) ? !score_ok : score_ok);
  assign scan_end    = (rd_pend && !scan_cont) || (!rd_pend && cur == len);
  assign presum_done = !rd_pend && (ptr == end_p);
  assign slide_end   = !sub && (!win_fit || sum_lt);

  // Final verdict on the kept span
  assign span      = tail_p - start_p;
  assign dropped_f = drop_early || (CW'(span) < minlen_c);
  assign trimmed_f = !dropped_f && (tail_p != len || start_p != '0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:   if (accept && last) state_next = ST_SIZE;
      ST_SIZE: begin
        if (drop_now) state_next = ST_DONE;
        else if (cfg.window_length != '0 || !auto_win) state_next = ST_SKIP;
        else state_next = ST_DIV;
      end
      ST_DIV:    if (div_done) state_next = ST_SKIP;
      ST_SKIP:   if (scan_end) state_next = ST_PRESUM;
      ST_PRESUM: if (presum_done) state_next = ST_SLIDE;
      ST_SLIDE:  if (slide_end) state_next = ST_EXTEND;
      ST_EXTEND: if (scan_end) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_LOAD;
      default:   state_next = ST_LOAD;
    endcase
  end

  // Handshake, store access and divider control
  always_comb begin
    char_ready = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_sel     = {1'b0, ptr};
    div_start  = 1'b0;
    case (state)
      ST_LOAD: begin
        char_ready = 1'b1;
        wr_en      = accept && (cnt < MAX_LEN);
      end
      ST_SIZE: begin
        div_start = !drop_now && cfg.window_length == '0 && auto_win;
      end
      ST_SKIP, ST_EXTEND: begin
        rd_en = !scan_end && (ptr < len);
      end
      ST_PRESUM: begin
        rd_en = ptr < end_p;
      end
      ST_SLIDE: begin
        if (!sub) begin
          rd_en  = !slide_end;
          rd_sel = {1'b0, cur};
        end else begin
          rd_en  = add_ok;
          rd_sel = cur_plus_win;
        end
      end
      default: ;
    endcase
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      sub       <= 1'b0;
      res_valid <= 1'b0;
      seen_cnt  <= '0;
      trim_cnt  <= '0;
      drop_cnt  <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      // Raise a new result, or drop the one just taken
      if (state == ST_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (accept) begin
            cnt <= last ? '0 : cnt_inc;
          end
        end
        ST_PRESUM: begin
          if (presum_done) sub <= 1'b0;
        end
        ST_SLIDE: begin
          if (!sub) begin
            if (!slide_end) sub <= 1'b1;
          end else begin
            sub <= 1'b0;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            seen_cnt  <= seen_cnt + 1'b1;
            if (dropped_f) drop_cnt <= drop_cnt + 1'b1;
            if (trimmed_f) trim_cnt <= trim_cnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Trimming datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        if (accept && last) len <= cnt_inc;
      end
      ST_SIZE: begin
        ptr        <= '0;
        cur        <= '0;
        sum        <= '0;
        drop_early <= drop_now;
        if (cfg.window_length != '0) win <= win_cfg;
        else if (!auto_win) win <= len;
      end
      ST_DIV: begin
        if (div_done) win <= div_quo;
      end
      ST_SKIP: begin
        if (rd_en) ptr <= ptr + 1'b1;
        if (scan_cont) cur <= cur + 1'b1;
        if (scan_end) begin
          start_p <= cur;
          tail_p  <= cur;
          ptr     <= cur;
          end_p   <= add_ok ? cur_plus_win[LW-1:0] : len;
          limit   <= $signed({2'b00, lim_prod});
        end
      end
      ST_PRESUM: begin
        if (rd_en) ptr <= ptr + 1'b1;
        if (rd_pend) sum <= sum + score_x;
        if (presum_done) cur <= start_p;
      end
      ST_SLIDE: begin
        if (!sub) begin
          if (win_fit) tail_p <= cur;
          if (!slide_end) begin
            sum <= sum_eff;
          end else begin
            ptr <= win_fit ? cur : tail_p;
            cur <= win_fit ? cur : tail_p;
          end
        end else begin
          // Drop the base leaving the window
          sum <= sum - score_x;
          cur <= cur + 1'b1;
        end
      end
      ST_EXTEND: begin
        if (rd_en) ptr <= ptr + 1'b1;
        if (scan_cont) cur <= cur + 1'b1;
        if (scan_end) tail_p <= cur;
      end
      ST_DONE: begin
        if (out_free) begin
          res.keep_start    <= dropped_f ? '0 : POS_W'(start_p);
          res.keep_end      <= dropped_f ? '0 : POS_W'(tail_p);
          res.dropped       <= dropped_f;
          res.trimmed       <= trimmed_f;
          res.reads_seen    <= seen_cnt + 1'b1;
          res.reads_trimmed <= trimmed_f ? trim_cnt + 1'b1 : trim_cnt;
          res.reads_dropped <= dropped_f ? drop_cnt + 1'b1 : drop_cnt;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/windowed_quality_trimmer.sv @@
// Top level of the sliding-window quality trimmer.
//
//   Channel   Signals                                   Moves
//   char      char_valid/char_ready, qual_char, last    one quality character per transfer
//   res       res_valid/res_ready, keep_start..         one trim result per read
//   apb       psel/penable/pwrite/paddr/pwdata/prdata   register writes and reads
//
// Each character is written to the store as it is accepted. After the last character the read is
// walked through the store's single read port: the window is sized (with an automatic divide
// when needed), failing bases are skipped, the first window is summed, the window slides
// (dropping the leaving base, then adding the entering one) and passing bases extend the end.
// rst (synchronous) clears control, counters and registers; the store is not cleared.
// A result waits in its register until res_ready; the next read loads meanwhile.
module windowed_quality_trimmer import wqt_pkg::*; #(
  parameter int MAX_READ_LEN = DEF_MAX_READ_LEN
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               char_valid,
  output logic               char_ready,
  input  logic [7:0]         qual_char,
  input  logic               last,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [POS_W-1:0]   keep_start,
  output logic [POS_W-1:0]   keep_end,
  output logic               dropped,
  output logic               trimmed,
  output logic [31:0]        reads_seen,
  output logic [31:0]        reads_trimmed,
  output logic [31:0]        reads_dropped
);

  wqt_cfg_t    cfg;
  wqt_result_t res;

  wqt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wqt_trim #(.MAX_READ_LEN(MAX_READ_LEN)) u_trim (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .qual_char  (qual_char),
    .last       (last),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Unpack the result register
  assign keep_start    = res.keep_start;
  assign keep_end      = res.keep_end;
  assign dropped       = res.dropped;
  assign trimmed       = res.trimmed;
  assign reads_seen    = res.reads_seen;
  assign reads_trimmed = res.reads_trimmed;
  assign reads_dropped = res.reads_dropped;

endmodule

@@ rtl/core/wqt_checker.sv @@
// Port-level checks for the trimmer, bound to the top level.
module wqt_checker import wqt_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             char_valid,
  input logic             char_ready,
  input logic             last,
  input logic             res_valid,
  input logic             res_ready,
  input logic [POS_W-1:0] keep_start,
  input logic [POS_W-1:0] keep_end,
  input logic             dropped,
  input logic             trimmed,
  input logic [31:0]      reads_seen
);

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // The last character closes the input while the read is trimmed
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_ready && last) |=> !char_ready)
    else $error("character taken during trimming");

  // A dropped read reports an empty, untrimmed span
  a_drop_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && dropped) |-> (keep_start == '0 && keep_end == '0 && !trimmed))
    else $error("dropped read with nonempty span");

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(reads_seen) && $stable(keep_end)))
    else $error("stalled result changed");

endmodule

bind windowed_quality_trimmer wqt_checker u_checker (.*);
